>>> hdl/bdpf_pkg.sv
// Shared types, codes and CRC-16 helpers for the boot download packet framer.
package bdpf_pkg;

    localparam int PAYLOAD_BYTES_DEF = 1024;

    // Action codes carried by an input item
    localparam logic [2:0] ACT_START  = 3'd0;
    localparam logic [2:0] ACT_IMAGE  = 3'd1;
    localparam logic [2:0] ACT_REPLY  = 3'd2;
    localparam logic [2:0] ACT_TMO    = 3'd3;
    localparam logic [2:0] ACT_FINISH = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_ADDR = 2'd1;
    localparam logic [1:0] CFG_SIZE = 2'd2;

    localparam logic [7:0] SOH_HDR  = 8'hFE;
    localparam logic [7:0] SOH_DATA = 8'hDA;
    localparam logic [7:0] SOH_END  = 8'hED;
    localparam logic [7:0] REPLY_OK = 8'hAA;

    typedef struct packed {
        logic        we;
        logic [1:0]  idx;
        logic [31:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [2:0] act;
        logic [7:0] db;
    } t_item;

    typedef struct packed {
        logic [7:0] data;
        logic       kind;
        logic       fend;
        logic       acc;
        logic       err;
    } t_res;

    typedef struct packed {
        logic       upd;
        logic       clr;
        logic [7:0] data;
    } t_crc_ctl;

    // Nibble table entry for poly 0x1021: n<<12 ^ n<<5 ^ n
    function automatic logic [15:0] crc_nib(input logic [3:0] n);
        crc_nib = {n, 12'h000} ^ {7'b0, n, 5'b0} ^ {12'h000, n};
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] c1;
        c1 = {c[11:0], 4'h0} ^ crc_nib(b[7:4] ^ c[15:12]);
        crc_byte = {c1[11:0], 4'h0} ^ crc_nib(b[3:0] ^ c1[15:12]);
    endfunction

endpackage

>>> hdl/bdpf_crc.sv
// Running CRC-16 register, updated one frame byte per cycle while i_ctl.upd is set.
module bdpf_crc
    import bdpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_crc_ctl    i_ctl,
    output logic [15:0] o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = crc_byte(i_ctl.clr ? 16'h0000 : r_crc, i_ctl.data);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= 16'h0000;
        end else if (i_ctl.upd) begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

>>> hdl/bdpf_ctrl.sv
// Link phase, frame counters, config registers and per-step result selection.
module bdpf_ctrl
    import bdpf_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg_wr     i_cfg,
    input  logic        i_hold_v,
    input  t_item       i_item,
    input  logic        i_adv,
    input  logic [15:0] i_crc,
    output t_res        o_res,
    output t_crc_ctl    o_crc_ctl
);

    localparam int BIF_W = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [3:0] HDR_LAST = 4'd13;
    localparam logic [3:0] FIN_LAST = 4'd4;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT_HDR, PH_DATA, PH_WAIT_DATA, PH_WAIT_END, PH_REJECTED
    } t_phase;

    typedef enum logic [2:0] {
        PL_ERR, PL_VERDICT, PL_HDR, PL_IMG, PL_FIN
    } t_plan;

    t_phase            r_phase, n_phase;
    logic [7:0]        r_seq, n_seq;
    logic [BIF_W-1:0]  r_bif, n_bif;
    logic [31:0]       r_rem, n_rem;
    logic [3:0]        r_step, n_step;
    logic [7:0]        r_mode;
    logic [31:0]       r_addr;
    logic [31:0]       r_size;

    t_plan      plan;
    logic       open_frm, close_frm, last, cov, ok_reply;
    logic [3:0] last_step;
    logic [2:0] sub;
    logic [7:0] step_byte;

    assign open_frm  = (r_bif == '0);
    assign close_frm = (r_bif == BIF_W'(PAYLOAD_BYTES - 1)) || (r_rem == 32'd1);
    assign ok_reply  = (i_item.act == ACT_REPLY) && (i_item.db == REPLY_OK);

    always_comb begin
        plan = PL_ERR;
        case (i_item.act)
            ACT_START: begin
                if (r_phase == PH_IDLE || r_phase == PH_REJECTED) plan = PL_HDR;
            end
            ACT_IMAGE: begin
                if (r_phase == PH_DATA && r_rem != 32'd0) plan = PL_IMG;
            end
            ACT_REPLY, ACT_TMO: begin
                if (r_phase == PH_WAIT_HDR || r_phase == PH_WAIT_DATA ||
                    r_phase == PH_WAIT_END) plan = PL_VERDICT;
            end
            ACT_FINISH: begin
                if (r_phase == PH_DATA && r_rem == 32'd0) plan = PL_FIN;
            end
            default: plan = PL_ERR;
        endcase
    end

    // Image sub-step: 0 SOH, 1 seq, 2 ~seq, 3 payload, 4 CRC hi, 5 CRC lo
    always_comb begin
        sub       = open_frm ? r_step[2:0] : r_step[2:0] + 3'd3;
        last_step = 4'd0;
        step_byte = 8'h00;
        cov       = 1'b0;
        unique case (plan)
            PL_HDR: begin
                last_step = HDR_LAST;
                cov       = (r_step < 4'd12);
                unique case (r_step)
                    4'd0:    step_byte = SOH_HDR;
                    4'd1:    step_byte = 8'h00;
                    4'd2:    step_byte = 8'hFF;
                    4'd3:    step_byte = r_mode;
                    4'd4:    step_byte = r_size[31:24];
                    4'd5:    step_byte = r_size[23:16];
                    4'd6:    step_byte = r_size[15:8];
                    4'd7:    step_byte = r_size[7:0];
                    4'd8:    step_byte = r_addr[31:24];
                    4'd9:    step_byte = r_addr[23:16];
                    4'd10:   step_byte = r_addr[15:8];
                    4'd11:   step_byte = r_addr[7:0];
                    4'd12:   step_byte = i_crc[15:8];
                    default: step_byte = i_crc[7:0];
                endcase
            end
            PL_IMG: begin
                last_step = {1'b0, (close_frm ? 3'd5 : 3'd3) - (open_frm ? 3'd0 : 3'd3)};
                cov       = (sub < 3'd4);
                unique case (sub)
                    3'd0:    step_byte = SOH_DATA;
                    3'd1:    step_byte = r_seq;
                    3'd2:    step_byte = ~r_seq;
                    3'd3:    step_byte = i_item.db;
                    3'd4:    step_byte = i_crc[15:8];
                    default: step_byte = i_crc[7:0];
                endcase
            end
            PL_FIN: begin
                last_step = FIN_LAST;
                cov       = (r_step < 4'd3);
                unique case (r_step[2:0])
                    3'd0:    step_byte = SOH_END;
                    3'd1:    step_byte = r_seq;
                    3'd2:    step_byte = ~r_seq;
                    3'd3:    step_byte = i_crc[15:8];
                    default: step_byte = i_crc[7:0];
                endcase
            end
            default: begin
                last_step = 4'd0;
            end
        endcase
    end

    assign last = (r_step == last_step);

    always_comb begin
        o_res.data = step_byte;
        o_res.kind = (plan == PL_ERR) || (plan == PL_VERDICT);
        o_res.fend = last;
        o_res.acc  = (plan == PL_VERDICT) && ok_reply;
        o_res.err  = (plan == PL_ERR);
        o_crc_ctl.upd  = i_hold_v && i_adv && cov;
        o_crc_ctl.clr  = (r_step == 4'd0) &&
                         ((plan == PL_HDR) || (plan == PL_FIN) || (plan == PL_IMG && open_frm));
        o_crc_ctl.data = step_byte;
    end

    // Phase and frame counters move only on an item's last step; the step count advances on the others
    always_comb begin
        n_phase = r_phase;
        n_seq   = r_seq;
        n_bif   = r_bif;
        n_rem   = r_rem;
        n_step  = r_step;
        if (i_hold_v && i_adv) begin
            if (!last) begin
                n_step = r_step + 4'd1;
            end else begin
                n_step = 4'd0;
                unique case (plan)
                    PL_HDR: begin
                        n_seq   = 8'd1;
                        n_bif   = '0;
                        n_rem   = r_size;
                        n_phase = PH_WAIT_HDR;
                    end
                    PL_IMG: begin
                        n_rem = r_rem - 32'd1;
                        if (close_frm) begin
                            n_bif   = '0;
                            n_seq   = r_seq + 8'd1;
                            n_phase = PH_WAIT_DATA;
                        end else begin
                            n_bif = r_bif + BIF_W'(1);
                        end
                    end
                    PL_FIN: n_phase = PH_WAIT_END;
                    PL_VERDICT: begin
                        if (ok_reply) n_phase = (r_phase == PH_WAIT_END) ? PH_IDLE : PH_DATA;
                        else          n_phase = PH_REJECTED;
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_seq   <= 8'd1;
            r_bif   <= '0;
            r_rem   <= 32'd0;
            r_step  <= 4'd0;
            r_mode  <= 8'd1;
            r_addr  <= 32'd0;
            r_size  <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_seq   <= n_seq;
            r_bif   <= n_bif;
            r_rem   <= n_rem;
            r_step  <= n_step;
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    CFG_MODE: r_mode <= i_cfg.data[7:0];
                    CFG_ADDR: r_addr <= i_cfg.data;
                    CFG_SIZE: r_size <= i_cfg.data;
                    default:  ;
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hold_v |-> (r_step <= last_step))
        else $error("step past end of item");
    a_bif_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bif < BIF_W'(PAYLOAD_BYTES))
        else $error("frame byte count overflow");
    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_hold_v |-> (r_step == 4'd0))
        else $error("step count left over without an item");
`endif

endmodule

>>> hdl/boot_download_packet_framer_top.sv
// Top level of the boot download packet framer: item hold stage and result register.
// An accepted item is registered in the hold stage, and each of its results then in the result register.
// Throughput: one result per cycle while i_out_ready holds; an item giving n results (1..14)
// stays held until its last result; the single result register is fed from the per-step byte selection.
// Single-result items (replies, errors, most image bytes) sustain one item per cycle while the output is ready.
// Reset: synchronous active-low; resets phase, counters (sequence 1), CRC, config (mode 1) and valids.
module boot_download_packet_framer_top
    import bdpf_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_data_byte,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_kind,
    output logic        o_frame_end,
    output logic        o_accepted,
    output logic        o_order_error,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    // Hold stage: the item being expanded into results
    logic     r_hv;
    t_item    r_item;
    // Result register
    logic     r_ov;
    t_res     r_res;

    t_res     step_res;
    t_crc_ctl crc_ctl;
    t_cfg_wr  cfg;
    logic [15:0] crc;
    logic     adv;
    logic     in_acc;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_wdata;

    // One step of the held item moves into the result register whenever it is empty or being drained
    assign adv        = r_hv && (!r_ov || i_out_ready);
    // The next item enters when none is held or as the held one issues its last result
    assign o_in_ready = !r_hv || (adv && step_res.fend);
    assign in_acc     = i_in_valid && o_in_ready;

    bdpf_ctrl #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_hold_v  (r_hv),
        .i_item    (r_item),
        .i_adv     (adv),
        .i_crc     (crc),
        .o_res     (step_res),
        .o_crc_ctl (crc_ctl)
    );

    bdpf_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_crc   (crc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
        end else if (in_acc) begin
            r_hv <= 1'b1;
        end else if (adv && step_res.fend) begin
            r_hv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item.act <= i_action;
            r_item.db  <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_out_byte    = r_res.data;
    assign o_out_kind    = r_res.kind;
    assign o_frame_end   = r_res.fend;
    assign o_accepted    = r_res.acc;
    assign o_order_error = r_res.err;

`ifndef NO_ASSERTIONS
    a_load_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_hv)
        else $error("accepted item not held");
    a_report_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_kind) |-> (o_frame_end && o_out_byte == 8'h00))
        else $error("verdict or error report malformed");
    a_err_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_order_error) |-> (o_out_kind && !o_accepted))
        else $error("order error with accepted flag");
    a_byte_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_kind) |-> (!o_accepted && !o_order_error))
        else $error("frame byte carries verdict flags");
`endif

endmodule
